### design/ps2hl_pkg.sv
// Shared types, codes and helpers for the PS/2 host link engine.
package ps2hl_pkg;

  typedef enum logic [1:0] {
    OP_EDGE   = 2'd0,
    OP_SEND   = 2'd1,
    OP_POP    = 2'd2,
    OP_REINIT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_ERROR = 2'd0,
    MODE_RECV  = 2'd1,
    MODE_SEND  = 2'd2
  } mode_t;

  localparam logic [3:0] FRAME_BITS = 4'd11;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctrl_t;

  // Odd parity bit: set when the byte holds an even number of ones.
  function automatic logic odd_parity(input logic [7:0] v);
    odd_parity = ~(^v);
  endfunction

endpackage

### design/ps2hl_if.sv
// Valid/ready channel interfaces for the PS/2 host link engine.
interface ps2hl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       data_line;
  logic [7:0] send_byte;

  modport source (output valid, output opcode, output data_line, output send_byte,
                  input ready);
  modport sink (input valid, input opcode, input data_line, input send_byte,
                output ready);
endinterface

interface ps2hl_out_if #(parameter int FIFO_DEPTH = 16);
  localparam int CountW = $clog2(FIFO_DEPTH + 1);

  logic              valid;
  logic              ready;
  logic [1:0]        link_mode;
  logic              data_pull_low;
  logic [7:0]        popped_byte;
  logic [CountW-1:0] fifo_count;

  modport source (output valid, output link_mode, output data_pull_low,
                  output popped_byte, output fifo_count, input ready);
  modport sink (input valid, input link_mode, input data_pull_low,
                input popped_byte, input fifo_count, output ready);
endinterface

### design/ps2hl_fifo.sv
// Receive byte FIFO: circular buffer memory with fill count and registered read.
module ps2hl_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ps2hl_pkg::fifo_ctrl_t              ctrl,
  input  logic [7:0]                         wdata,
  output logic [7:0]                         rdata,
  output logic [$clog2(DEPTH+1)-1:0]         fill,
  output logic [$clog2(DEPTH+1)-1:0]         fill_next
);

  localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CountW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0]   LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CountW-1:0] Full    = CountW'(DEPTH);

  logic [7:0]      mem [DEPTH];
  logic [PtrW-1:0] head, head_next;
  logic [PtrW-1:0] tail, tail_next;
  logic            do_push, do_pop;

  assign do_push = ctrl.push && (fill != Full);
  assign do_pop  = ctrl.pop && (fill != '0);

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    if (ctrl.clear) begin
      head_next = '0;
      tail_next = '0;
      fill_next = '0;
    end else if (do_push) begin
      tail_next = (tail == LastPtr) ? '0 : tail + PtrW'(1);
      fill_next = fill + CountW'(1);
    end else if (do_pop) begin
      head_next = (head == LastPtr) ? '0 : head + PtrW'(1);
      fill_next = fill - CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      rdata <= mem[head];
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= Full)
    else $error("fifo fill exceeds depth");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> head == tail)
    else $error("empty fifo with unequal pointers");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    fill == Full && ctrl.push && !ctrl.clear |=> fill == Full)
    else $error("push on full fifo changed fill");

endmodule

### design/ps2_host_link_engine_unit.sv
// PS/2 host link engine top level: frame receive/send sequencing and result register.
// Latency: a result is valid the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; ready stays high while the result
// register is empty or being drained.
// Reset (synchronous, rst high): receive mode, falling edge expected, bit counter 11,
// DATA released, FIFO empty, no result pending.
module ps2_host_link_engine_unit #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  ps2hl_in_if.sink         in_ch,
  ps2hl_out_if.source      out_ch
);

  localparam int CountW = $clog2(FIFO_DEPTH + 1);

  ps2hl_pkg::mode_t      mode, mode_next;
  logic                  expect_rising, expect_rising_next;
  logic [3:0]            bit_counter, bit_counter_next;
  logic [7:0]            shift_reg, shift_reg_next;
  logic                  saved_parity, saved_parity_next;
  logic                  pull_low, pull_low_next;

  logic                  out_valid;
  ps2hl_pkg::mode_t      out_mode;
  logic                  out_pull;
  logic                  out_pop_hit, out_pop_hit_next;
  logic [CountW-1:0]     out_count;

  ps2hl_pkg::fifo_ctrl_t fifo_ctrl;
  logic [7:0]            fifo_rdata;
  logic [CountW-1:0]     fifo_fill, fifo_fill_next;

  logic                  accept;
  logic [3:0]            bc_dec;
  ps2hl_pkg::op_t        op;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign op          = ps2hl_pkg::op_t'(in_ch.opcode);
  assign bc_dec      = bit_counter - 4'd1;

  ps2hl_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (fifo_ctrl),
    .wdata     (shift_reg),
    .rdata     (fifo_rdata),
    .fill      (fifo_fill),
    .fill_next (fifo_fill_next)
  );

  // Next state
  always_comb begin
    mode_next          = mode;
    expect_rising_next = expect_rising;
    bit_counter_next   = bit_counter;
    shift_reg_next     = shift_reg;
    saved_parity_next  = saved_parity;
    pull_low_next      = pull_low;
    fifo_ctrl          = '0;
    if (accept) begin
      unique case (op)
        ps2hl_pkg::OP_EDGE: begin
          if (mode == ps2hl_pkg::MODE_RECV || mode == ps2hl_pkg::MODE_SEND) begin
            if (!expect_rising) begin
              expect_rising_next = 1'b1;
              if (mode == ps2hl_pkg::MODE_RECV) begin
                if (bit_counter == ps2hl_pkg::FRAME_BITS && in_ch.data_line)
                  mode_next = ps2hl_pkg::MODE_ERROR;
                if (bit_counter < ps2hl_pkg::FRAME_BITS && bit_counter > 4'd2)
                  shift_reg_next = {in_ch.data_line, shift_reg[7:1]};
                if (bit_counter == 4'd2 &&
                    ps2hl_pkg::odd_parity(shift_reg) != in_ch.data_line)
                  mode_next = ps2hl_pkg::MODE_ERROR;
                if (bit_counter == 4'd1 && !in_ch.data_line)
                  mode_next = ps2hl_pkg::MODE_ERROR;
              end else begin
                if (bit_counter == ps2hl_pkg::FRAME_BITS)
                  saved_parity_next = ps2hl_pkg::odd_parity(shift_reg);
                if (bit_counter <= ps2hl_pkg::FRAME_BITS && bit_counter > 4'd3) begin
                  pull_low_next  = ~shift_reg[0];
                  shift_reg_next = {1'b0, shift_reg[7:1]};
                end
                if (bit_counter == 4'd3)
                  pull_low_next = ~saved_parity;
                if (bit_counter == 4'd2)
                  pull_low_next = 1'b0;
                if (bit_counter == 4'd1 && in_ch.data_line)
                  mode_next = ps2hl_pkg::MODE_ERROR;
              end
            end else begin
              expect_rising_next = 1'b0;
              bit_counter_next   = bc_dec;
              if (bc_dec == 4'd0) begin
                bit_counter_next = ps2hl_pkg::FRAME_BITS;
                if (mode == ps2hl_pkg::MODE_RECV)
                  fifo_ctrl.push = 1'b1;
                else
                  mode_next = ps2hl_pkg::MODE_RECV;
              end
            end
          end
        end
        ps2hl_pkg::OP_SEND: begin
          fifo_ctrl.clear    = 1'b1;
          shift_reg_next     = in_ch.send_byte;
          pull_low_next      = 1'b1;
          mode_next          = ps2hl_pkg::MODE_SEND;
          expect_rising_next = 1'b0;
          bit_counter_next   = ps2hl_pkg::FRAME_BITS;
        end
        ps2hl_pkg::OP_POP: begin
          fifo_ctrl.pop = 1'b1;
        end
        ps2hl_pkg::OP_REINIT: begin
          fifo_ctrl.clear    = 1'b1;
          pull_low_next      = 1'b0;
          mode_next          = ps2hl_pkg::MODE_RECV;
          expect_rising_next = 1'b0;
          bit_counter_next   = ps2hl_pkg::FRAME_BITS;
        end
      endcase
    end
  end

  // Result fields
  always_comb begin
    out_pop_hit_next = (op == ps2hl_pkg::OP_POP) && (fifo_fill != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= ps2hl_pkg::MODE_RECV;
      expect_rising <= 1'b0;
      bit_counter   <= ps2hl_pkg::FRAME_BITS;
      shift_reg     <= '0;
      saved_parity  <= 1'b0;
      pull_low      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      mode          <= mode_next;
      expect_rising <= expect_rising_next;
      bit_counter   <= bit_counter_next;
      shift_reg     <= shift_reg_next;
      saved_parity  <= saved_parity_next;
      pull_low      <= pull_low_next;
      if (accept)
        out_valid <= 1'b1;
      else if (out_ch.ready)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_mode    <= mode_next;
      out_pull    <= pull_low_next;
      out_pop_hit <= out_pop_hit_next;
      out_count   <= fifo_fill_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.link_mode     = out_mode;
  assign out_ch.data_pull_low = out_pull;
  assign out_ch.popped_byte   = out_pop_hit ? fifo_rdata : 8'd0;
  assign out_ch.fifo_count    = out_count;

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    bit_counter >= 4'd1 && bit_counter <= ps2hl_pkg::FRAME_BITS)
    else $error("bit counter out of frame range");
  a_pull_only_send: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_mode != ps2hl_pkg::MODE_SEND |-> !out_pull)
    else $error("DATA pulled low outside send mode");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("input stalled with empty result register");
  a_error_frozen: assert property (@(posedge clk) disable iff (rst)
    mode == ps2hl_pkg::MODE_ERROR && accept && op == ps2hl_pkg::OP_EDGE
    |=> mode == ps2hl_pkg::MODE_ERROR && $stable(bit_counter) && $stable(shift_reg))
    else $error("edge changed state in error mode");

endmodule

### sim/ps2_host_link_engine_unit_tb.sv
// Testbench for ps2_host_link_engine_unit: frame stimulus against a scoreboard.
`timescale 1ns / 1ps

typedef struct {
  ps2hl_pkg::mode_t mode;
  logic             pull;
  logic [7:0]       popped;
  logic [4:0]       count;
} link_status_t;

class link_scoreboard;
  int unsigned      depth;
  ps2hl_pkg::mode_t mode;
  bit               rising;
  logic [3:0]       bit_cnt;
  logic [7:0]       shreg;
  bit               par_saved;
  bit               pull;
  logic [7:0]       rx_bytes[$];
  link_status_t     status_q[$];
  int               errors;

  function new(int unsigned d);
    depth     = d;
    mode      = ps2hl_pkg::MODE_RECV;
    rising    = 1'b0;
    bit_cnt   = ps2hl_pkg::FRAME_BITS;
    shreg     = 8'h00;
    par_saved = 1'b0;
    pull      = 1'b0;
    errors    = 0;
  endfunction

  // rising edge: one bit done; returns 1 at end of frame
  function bit step_bit();
    rising  = 1'b0;
    bit_cnt = bit_cnt - 4'd1;
    if (bit_cnt == 4'd0) begin
      bit_cnt = ps2hl_pkg::FRAME_BITS;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void accept_cmd(ps2hl_pkg::op_t op, logic d, logic [7:0] b);
    link_status_t s;
    s.popped = 8'h00;
    case (op)
      ps2hl_pkg::OP_EDGE: begin
        if (mode == ps2hl_pkg::MODE_RECV) begin
          if (!rising) begin
            if (bit_cnt == ps2hl_pkg::FRAME_BITS && d) mode = ps2hl_pkg::MODE_ERROR;
            if (bit_cnt < ps2hl_pkg::FRAME_BITS && bit_cnt > 4'd2) shreg = {d, shreg[7:1]};
            if (bit_cnt == 4'd2 && (~^shreg) != d) mode = ps2hl_pkg::MODE_ERROR;
            if (bit_cnt == 4'd1 && !d) mode = ps2hl_pkg::MODE_ERROR;
            rising = 1'b1;
          end else if (step_bit()) begin
            if (rx_bytes.size() < depth) rx_bytes.push_back(shreg);
          end
        end else if (mode == ps2hl_pkg::MODE_SEND) begin
          if (!rising) begin
            if (bit_cnt == ps2hl_pkg::FRAME_BITS) par_saved = ~^shreg;
            if (bit_cnt > 4'd3) begin
              pull  = ~shreg[0];
              shreg = shreg >> 1;
            end
            if (bit_cnt == 4'd3) pull = ~par_saved;
            if (bit_cnt == 4'd2) pull = 1'b0;
            if (bit_cnt == 4'd1 && d) mode = ps2hl_pkg::MODE_ERROR;
            rising = 1'b1;
          end else if (step_bit()) begin
            mode = ps2hl_pkg::MODE_RECV;
          end
        end
      end
      ps2hl_pkg::OP_SEND: begin
        rx_bytes.delete();
        shreg   = b;
        pull    = 1'b1;
        mode    = ps2hl_pkg::MODE_SEND;
        rising  = 1'b0;
        bit_cnt = ps2hl_pkg::FRAME_BITS;
      end
      ps2hl_pkg::OP_POP: begin
        if (rx_bytes.size() > 0) s.popped = rx_bytes.pop_front();
      end
      default: begin
        rx_bytes.delete();
        pull    = 1'b0;
        mode    = ps2hl_pkg::MODE_RECV;
        rising  = 1'b0;
        bit_cnt = ps2hl_pkg::FRAME_BITS;
      end
    endcase
    s.mode  = mode;
    s.pull  = pull;
    s.count = 5'(rx_bytes.size());
    status_q.push_back(s);
  endfunction

  function void compare(string what, logic [7:0] exp, logic [7:0] got);
    if (got !== exp) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp, got);
    end
  endfunction

  function void check_status(logic [1:0] m, logic p, logic [7:0] pb, logic [4:0] cnt);
    link_status_t s;
    if (status_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual mode %0d count %0d",
               $time, m, cnt);
    end else begin
      s = status_q.pop_front();
      compare("link_mode", 8'(s.mode), 8'(m));
      compare("data_pull_low", 8'(s.pull), 8'(p));
      compare("popped_byte", s.popped, pb);
      compare("fifo_count", 8'(s.count), 8'(cnt));
    end
  endfunction

  function int pending();
    return status_q.size();
  endfunction
endclass

module ps2_host_link_engine_unit_tb;
  localparam int Depth    = 16;
  localparam int NumItems = 700;
  localparam int Limit    = 200000;

  logic clk = 1'b0;
  logic rst;

  ps2hl_in_if                       in_ch();
  ps2hl_out_if #(.FIFO_DEPTH(Depth)) out_ch();

  ps2_host_link_engine_unit #(.FIFO_DEPTH(Depth)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  link_scoreboard sb = new(Depth);
  int  items;
  int  cycles;
  bit  quiet_src;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= Limit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_status(out_ch.link_mode, out_ch.data_pull_low, out_ch.popped_byte,
                      5'(out_ch.fifo_count));
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: random back-pressure plus one long hold-off
  initial begin
    int  hold;
    int  sink_cycles;
    bit  quiet_sink;
    hold        = 0;
    sink_cycles = 0;
    quiet_sink  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else begin
        sink_cycles++;
        if (sink_cycles % 128 == 0) quiet_sink = ($urandom_range(0, 3) == 0);
        if (sink_cycles == 600) hold = 250;
        else if (hold == 0 && !quiet_sink && $urandom_range(0, 7) == 0) hold = idle_len();
        if (hold > 0) begin
          hold--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  task automatic put_item(ps2hl_pkg::op_t op, logic d, logic [7:0] b);
    int gap;
    gap = 0;
    if (!quiet_src && $urandom_range(0, 99) >= 65) gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.data_line <= d;
    in_ch.send_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.accept_cmd(op, d, b);
    items++;
  endtask

  task automatic edge_item(logic d);
    put_item(ps2hl_pkg::OP_EDGE, d, 8'($urandom));
  endtask

  // device-to-host frame; bad_bit >= 0 flips that bit of the frame
  task automatic rx_frame(logic [7:0] v, int bad_bit);
    logic [10:0] bits;
    bits = {1'b1, ~^v, v, 1'b0};
    if (bad_bit >= 0) bits[bad_bit] = ~bits[bad_bit];
    for (int i = 0; i < 11; i++) begin
      edge_item(bits[i]);
      edge_item(1'($urandom));
    end
  endtask

  // host-to-device frame; ack level sampled on the last falling edge
  task automatic tx_frame(logic [7:0] v, logic ack);
    put_item(ps2hl_pkg::OP_SEND, 1'($urandom), v);
    for (int i = 0; i < 11; i++) begin
      edge_item((i == 10) ? ack : 1'($urandom));
      edge_item(1'($urandom));
    end
  endtask

  task automatic reinit();
    put_item(ps2hl_pkg::OP_REINIT, 1'($urandom), 8'($urandom));
  endtask

  task automatic pop_item();
    put_item(ps2hl_pkg::OP_POP, 1'($urandom), 8'($urandom));
  endtask

  initial begin
    int r;
    int bad;
    items     = 0;
    quiet_src = 1'b0;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= ps2hl_pkg::OP_EDGE;
    in_ch.data_line <= 1'b0;
    in_ch.send_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed
    pop_item();
    reinit();
    edge_item(1'b1);           // bad start bit
    edge_item(1'b0);           // ignored while in error
    pop_item();
    put_item(ps2hl_pkg::OP_SEND, 1'b0, 8'h00);
    put_item(ps2hl_pkg::OP_SEND, 1'b1, 8'hFF);
    edge_item(1'b1);
    edge_item(1'b0);
    reinit();
    edge_item(1'b0);
    edge_item(1'b1);
    put_item(ps2hl_pkg::OP_REINIT, 1'b1, 8'hFF);
    tx_frame(8'hA5, 1'b1);      // missing ACK
    pop_item();

    // fill past full, then drain past empty
    reinit();
    repeat (Depth + 2) rx_frame(8'($urandom), -1);
    repeat (Depth + 2) pop_item();

    while (items < NumItems) begin
      if ($urandom_range(0, 9) == 0) quiet_src = ~quiet_src;
      r = $urandom_range(0, 99);
      if (r < 40) begin
        bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : -1;
        rx_frame(8'($urandom), bad);
        if (bad >= 0 && $urandom_range(0, 4) != 0) reinit();
      end else if (r < 55) begin
        bad = ($urandom_range(0, 7) == 0);
        tx_frame(8'($urandom), 1'(bad));
        if (bad != 0 && $urandom_range(0, 4) != 0) reinit();
      end else if (r < 75) begin
        repeat ($urandom_range(1, 4)) pop_item();
      end else if (r < 80) begin
        reinit();
      end else begin
        repeat ($urandom_range(1, 6))
          put_item(ps2hl_pkg::op_t'($urandom_range(0, 3)), 1'($urandom), 8'($urandom));
        if ($urandom_range(0, 4) != 0) reinit();
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
